// File: hw/rtl/tff_pkg.sv
// ----------------------------------------------------------------------------
// tff_pkg
// Shared types and constants of the ternary-weight FIR filter: register
// indexes, reset values, weight codes and the control group of the MAC unit.
// ----------------------------------------------------------------------------
package tff_pkg;

    localparam int MAX_TAPS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int IN_BITS   = 16;
    localparam int OUT_BITS  = 20;
    localparam int GAIN_BITS = 16;
    localparam int CFG_BITS  = 32;
    localparam int IDX_BITS  = 2;
    localparam int TC_BITS   = 5;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] CFG_TAP_COUNT     = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_TAP_WEIGHTS   = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_DITHER_ENABLE = 2'd2;
    localparam logic [IDX_BITS-1:0] CFG_OUTPUT_GAIN   = 2'd3;

    // reset values
    localparam logic [TC_BITS-1:0]   RST_TAP_COUNT   = 5'd16;
    localparam logic [CFG_BITS-1:0]  RST_TAP_WEIGHTS = 32'h0005_5555;
    localparam logic                 RST_DITHER_EN   = 1'b1;
    localparam logic [GAIN_BITS-1:0] RST_OUTPUT_GAIN = 16'd6554;

    // 0.01 in unsigned Q0.22, and the right shift of 22 back to integer scale
    localparam logic [16:0] DITHER_SCALE = 17'd41943;
    localparam int          DITHER_SHIFT = 22;

    // ternary weight codes; 2'b10 has no meaning and acts as zero
    localparam logic [1:0] W_ZERO  = 2'b00;
    localparam logic [1:0] W_PLUS  = 2'b01;
    localparam logic [1:0] W_MINUS = 2'b11;

    typedef struct packed {
        logic clear;
        logic acc_en;
        logic mul_lo;
        logic mul_hi;
    } t_mac_ctrl;

endpackage

// File: hw/rtl/ternary_fir_filter_top.sv
// ----------------------------------------------------------------------------
// ternary_fir_filter_top
// Per item: ST_WRITE, ST_TAPS, ST_DRAIN, ST_MUL_LO, ST_MUL_HI, then ST_DONE.
// Input is taken only in ST_IDLE, after the last result is loaded. ST_TAPS
// reads one history entry per cycle: single read port, one shared accumulator.
// Reset (synchronous, active low): registers to defaults, history reads zero,
// write slot zero, no result pending.
// ----------------------------------------------------------------------------
module ternary_fir_filter_top #(
    parameter int MAX_TAPS    = tff_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = tff_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tff_pkg::IDX_BITS-1:0]        i_cfg_idx,
    input  logic [tff_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [tff_pkg::IN_BITS-1:0]  i_sample_in,
    input  logic signed [tff_pkg::IN_BITS-1:0]  i_dither_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [tff_pkg::OUT_BITS-1:0] o_filtered_out
);
    import tff_pkg::*;

    localparam int IW = $clog2(MAX_TAPS);
    localparam int NW = $clog2(MAX_TAPS + 1);
    localparam int TW = (NW > TC_BITS) ? NW : TC_BITS;
    localparam int XW = ((SAMPLE_BITS > IN_BITS + 1) ? SAMPLE_BITS : IN_BITS + 1) + 1;
    localparam logic signed [XW-1:0] X_HI = XW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] X_LO = -X_HI - XW'(1);
    localparam logic [TW-1:0] TW_MAX = TW'(MAX_TAPS);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_WRITE  = 7'b0000010,
        ST_TAPS   = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_MUL_LO = 7'b0010000,
        ST_MUL_HI = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [TC_BITS-1:0]   r_tap_count;
    logic [CFG_BITS-1:0]  r_tap_weights;
    logic                 r_dither_en;
    logic [GAIN_BITS-1:0] r_gain;

    logic signed [IN_BITS-1:0]  r_sample;
    logic signed [IN_BITS-1:0]  r_dither;
    logic [IW-1:0]              r_write_slot;
    logic [IW-1:0]              r_addr;
    logic [IW-1:0]              r_tap;
    logic [1:0]                 r_code;
    logic                       r_rd_go;
    logic                       r_out_valid;
    logic signed [OUT_BITS-1:0] r_out;

    logic [TW-1:0]                w_n;
    logic [IW-1:0]                w_last;
    logic [IW-1:0]                w_slot;
    logic signed [33:0]           w_dmul;
    logic signed [33:0]           w_dround;
    logic signed [11:0]           w_scaled;
    logic signed [XW-1:0]         w_xwide;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic [CFG_BITS-1:0]          w_wshift;
    logic signed [SAMPLE_BITS-1:0] w_rd_data;
    logic signed [OUT_BITS-1:0]   w_result;
    logic                         w_accept;
    logic                         w_load_out;
    t_mac_ctrl                    w_ctrl;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count   <= RST_TAP_COUNT;
            r_tap_weights <= RST_TAP_WEIGHTS;
            r_dither_en   <= RST_DITHER_EN;
            r_gain        <= RST_OUTPUT_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAP_COUNT:     r_tap_count   <= i_cfg_data[TC_BITS-1:0];
                CFG_TAP_WEIGHTS:   r_tap_weights <= i_cfg_data;
                CFG_DITHER_ENABLE: r_dither_en   <= i_cfg_data[0];
                CFG_OUTPUT_GAIN:   r_gain        <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- tap count and ring slot ----------------
    always_comb begin
        if (r_tap_count == '0) begin
            w_n = TW'(1);
        end else if (TW'(r_tap_count) > TW_MAX) begin
            w_n = TW_MAX;
        end else begin
            w_n = TW'(r_tap_count);
        end
    end

    assign w_last = IW'(w_n - TW'(1));
    // slot left stale by a lowered tap count restarts at zero
    assign w_slot = (r_write_slot > w_last) ? '0 : r_write_slot;

    // ---------------- dither and saturation ----------------
    assign w_dmul   = r_dither * $signed({1'b0, DITHER_SCALE});
    assign w_dround = w_dmul + (34'sd1 <<< (DITHER_SHIFT - 1));
    assign w_scaled = $signed(w_dround[33:DITHER_SHIFT]);
    assign w_xwide  = XW'(r_sample) + (r_dither_en ? XW'(w_scaled) : '0);

    always_comb begin
        if (w_xwide > X_HI) begin
            w_x = SAMPLE_BITS'(X_HI);
        end else if (w_xwide < X_LO) begin
            w_x = SAMPLE_BITS'(X_LO);
        end else begin
            w_x = SAMPLE_BITS'(w_xwide);
        end
    end

    // taps at sixteen and beyond shift past the weight word and read as zero
    assign w_wshift = r_tap_weights >> {r_tap, 1'b0};

    // ---------------- sequencer ----------------
    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_TAPS;
            ST_TAPS:   if (r_tap == w_last) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_DONE;
            ST_DONE:   if (w_load_out) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_write_slot <= '0;
            r_rd_go      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_go <= (r_state == ST_TAPS);
            if (r_state == ST_WRITE) begin
                r_write_slot <= (w_slot == w_last) ? '0 : w_slot + IW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample_in;
            r_dither <= i_dither_sample;
        end
        if (r_state == ST_WRITE) begin
            r_addr <= w_slot;
            r_tap  <= '0;
        end else if (r_state == ST_TAPS) begin
            r_addr <= (r_addr == '0) ? w_last : r_addr - IW'(1);
            r_tap  <= r_tap + IW'(1);
        end
        r_code <= w_wshift[1:0];
        if (w_load_out) begin
            r_out <= w_result;
        end
    end

    // ---------------- datapath units ----------------
    tff_history #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_BITS)
    ) u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (r_state == ST_WRITE),
        .i_wr_addr (w_slot),
        .i_wr_data (w_x),
        .i_rd_en   (r_state == ST_TAPS),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_ctrl.clear  = (r_state == ST_WRITE);
    assign w_ctrl.acc_en = r_rd_go;
    assign w_ctrl.mul_lo = (r_state == ST_MUL_LO);
    assign w_ctrl.mul_hi = (r_state == ST_MUL_HI);

    tff_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_code   (r_code),
        .i_data   (w_rd_data),
        .i_gain   (r_gain),
        .o_result (w_result)
    );

    assign o_valid        = r_out_valid;
    assign o_filtered_out = r_out;

endmodule

// File: hw/rtl/tff_history.sv
// ----------------------------------------------------------------------------
// tff_history
// Sample history ring: one write port, one registered read port. Per-entry
// valid bits cleared at reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tff_history #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic signed [WIDTH-1:0]  i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic signed [WIDTH-1:0]  o_rd_data
);
    logic signed [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]        r_valid;
    logic signed [WIDTH-1:0] r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: hw/rtl/tff_mac.sv
// ----------------------------------------------------------------------------
// tff_mac
// Shared accumulator for the ternary tap sum, followed by a two-step gain
// multiply (low and high gain byte) and floor/saturate to the output width.
// ----------------------------------------------------------------------------
module tff_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_TAPS    = 16
) (
    input  logic                                i_clk,
    input  tff_pkg::t_mac_ctrl                  i_ctrl,
    input  logic [1:0]                          i_code,
    input  logic signed [SAMPLE_BITS-1:0]       i_data,
    input  logic [tff_pkg::GAIN_BITS-1:0]       i_gain,
    output logic signed [tff_pkg::OUT_BITS-1:0] o_result
);
    import tff_pkg::*;

    // only the first sixteen taps carry weights
    localparam int NW = (MAX_TAPS < 16) ? MAX_TAPS : 16;
    localparam int AW = SAMPLE_BITS + $clog2(NW) + 1;
    localparam int PW = AW + GAIN_BITS + 1;
    localparam logic signed [PW-1:0] Y_HI = PW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] Y_LO = -Y_HI - PW'(1);

    logic signed [AW-1:0]  r_acc;
    logic signed [PW-1:0]  r_prod;
    logic signed [AW-1:0]  w_data;
    logic signed [AW+8:0]  w_plo;
    logic signed [AW+8:0]  w_phi;
    logic signed [PW-1:0]  w_y;

    assign w_data = AW'(i_data);
    assign w_plo  = r_acc * $signed({1'b0, i_gain[7:0]});
    assign w_phi  = r_acc * $signed({1'b0, i_gain[15:8]});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            case (i_code)
                W_PLUS:  r_acc <= r_acc + w_data;
                W_MINUS: r_acc <= r_acc - w_data;
                default: r_acc <= r_acc;
            endcase
        end
        if (i_ctrl.mul_lo) begin
            r_prod <= PW'(w_plo);
        end else if (i_ctrl.mul_hi) begin
            r_prod <= r_prod + $signed({w_phi, 8'h00});
        end
    end

    // arithmetic shift floors toward minus infinity
    assign w_y = r_prod >>> GAIN_BITS;

    always_comb begin
        if (w_y > Y_HI) begin
            o_result = OUT_BITS'(Y_HI);
        end else if (w_y < Y_LO) begin
            o_result = OUT_BITS'(Y_LO);
        end else begin
            o_result = OUT_BITS'(w_y);
        end
    end

endmodule

// File: test/ternary_fir_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_fir_filter_top_tb
// Self-checking bench for the ternary-weight FIR filter. Items are driven
// through valid/ready with random gaps and random output stalls. Each
// transfer is fed to a behavioral copy of the dither, history ring and
// tap sum, and the scaled results are compared in order. Registers change
// only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module ternary_fir_filter_top_tb;
    import tff_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int IDLE_PCT       = 36;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = MAX_TAPS_DEF + 10;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_ITEMS    = 168;

    typedef struct {
        logic signed [IN_BITS-1:0] sample;
        logic signed [IN_BITS-1:0] dither;
    } t_filter_item;

    logic                       i_clk;
    logic                       i_rst_n         = 1'b0;
    logic                       i_cfg_we        = 1'b0;
    logic [IDX_BITS-1:0]        i_cfg_idx       = '0;
    logic [CFG_BITS-1:0]        i_cfg_data      = '0;
    logic                       i_valid         = 1'b0;
    logic                       o_ready;
    logic signed [IN_BITS-1:0]  i_sample_in     = '0;
    logic signed [IN_BITS-1:0]  i_dither_sample = '0;
    logic                       o_valid;
    logic                       i_ready         = 1'b0;
    logic signed [OUT_BITS-1:0] o_filtered_out;

    ternary_fir_filter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_in     (i_sample_in),
        .i_dither_sample (i_dither_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_filtered_out  (o_filtered_out)
    );

    // filter state and register copy
    logic signed [IN_BITS-1:0]  hist_model [MAX_TAPS_DEF];
    int unsigned                wr_slot_model;
    logic [TC_BITS-1:0]         tap_count_model;
    logic [CFG_BITS-1:0]        weights_model;
    logic                       dither_en_model;
    logic [GAIN_BITS-1:0]       gain_model;

    t_filter_item               sample_queue [$];
    logic signed [OUT_BITS-1:0] pending_filtered [$];
    int                         items_queued   = 0;
    int                         items_accepted = 0;
    int                         fail_count     = 0;
    int                         cycle_count    = 0;
    bit                         steady         = 1'b0;
    int                         hold_reqs      = 0;
    int                         hold_taken     = 0;
    int                         hold_left      = 0;
    t_filter_item               drv_item;
    logic signed [OUT_BITS-1:0] want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // dither, ring write and ternary tap sum for one item
    function automatic logic signed [OUT_BITS-1:0] next_filtered(
        input logic signed [IN_BITS-1:0] s,
        input logic signed [IN_BITS-1:0] d
    );
        int unsigned taps;
        int unsigned slot;
        int unsigned h;
        longint      x;
        longint      acc;
        longint      y;
        logic [1:0]  code;
        taps = tap_count_model;
        if (taps == 0) taps = 1;
        if (taps > MAX_TAPS_DEF) taps = MAX_TAPS_DEF;
        x = s;
        if (dither_en_model) begin
            x += (longint'(d) * longint'(DITHER_SCALE) + (longint'(1) << (DITHER_SHIFT - 1)))
                 >>> DITHER_SHIFT;
        end
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        slot = wr_slot_model;
        if (slot >= taps) slot = 0;   // ring was shortened under the write pointer
        hist_model[slot] = x[IN_BITS-1:0];
        wr_slot_model = (slot + 1) % taps;
        acc = 0;
        for (int unsigned i = 0; i < taps; i++) begin
            h = (slot + taps - i) % taps;
            code = weights_model[2*i +: 2];
            if (code == W_PLUS) acc += hist_model[h];
            else if (code == W_MINUS) acc -= hist_model[h];
        end
        y = (acc * longint'(gain_model)) >>> GAIN_BITS;
        if (y > 524287) y = 524287;
        if (y < -524288) y = -524288;
        return y[OUT_BITS-1:0];
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                pending_filtered.push_back(next_filtered(i_sample_in, i_dither_sample));
                items_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    drv_item = sample_queue.pop_front();
                    i_valid <= 1'b1;
                    i_sample_in <= drv_item.sample;
                    i_dither_sample <= drv_item.dither;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_filtered.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %0d at cycle %0d", o_filtered_out,
                                 cycle_count);
                end else begin
                    want = pending_filtered.pop_front();
                    if (o_filtered_out !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("filtered_out mismatch at cycle %0d: expected %0d, got %0d",
                                     cycle_count, want, o_filtered_out);
                    end
                end
            end
            if (hold_taken != hold_reqs) begin
                hold_taken++;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ternary_fir_filter_top_tb NOT OK");
            $finish;
        end
    end

    task automatic queue_item(input logic signed [IN_BITS-1:0] s,
                              input logic signed [IN_BITS-1:0] d);
        t_filter_item it;
        it.sample = s;
        it.dither = d;
        sample_queue.push_back(it);
        items_queued++;
    endtask

    task automatic queue_random_item();
        logic signed [IN_BITS-1:0] s;
        logic signed [IN_BITS-1:0] d;
        case ($urandom_range(9))
            0:       s = 16'sh7FFF;
            1:       s = -16'sh8000;
            2:       s = IN_BITS'(int'($urandom_range(511)) - 256);
            default: s = IN_BITS'($urandom);
        endcase
        case ($urandom_range(3))
            0:       d = IN_BITS'($urandom);
            1:       d = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
            default: d = IN_BITS'(int'($urandom_range(8191)) - 4096);
        endcase
        queue_item(s, d);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TAP_COUNT:     tap_count_model = val[TC_BITS-1:0];
            CFG_TAP_WEIGHTS:   weights_model   = val;
            CFG_DITHER_ENABLE: dither_en_model = val[0];
            CFG_OUTPUT_GAIN:   gain_model      = val[GAIN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [TC_BITS-1:0] tc, input logic [CFG_BITS-1:0] w,
                              input logic de, input logic [GAIN_BITS-1:0] g);
        write_reg(CFG_TAP_COUNT, CFG_BITS'(tc));
        write_reg(CFG_TAP_WEIGHTS, w);
        write_reg(CFG_DITHER_ENABLE, CFG_BITS'(de));
        write_reg(CFG_OUTPUT_GAIN, CFG_BITS'(g));
    endtask

    // block has drained once every transfer has its result back
    task automatic wait_idle();
        while (items_accepted != items_queued || pending_filtered.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [TC_BITS-1:0]   tc;
        logic [CFG_BITS-1:0]  w;
        logic                 de;
        logic [GAIN_BITS-1:0] g;
        int                   fill;

        for (int i = 0; i < MAX_TAPS_DEF; i++) hist_model[i] = '0;
        wr_slot_model   = 0;
        tap_count_model = RST_TAP_COUNT;
        weights_model   = RST_TAP_WEIGHTS;
        dither_en_model = RST_DITHER_EN;
        gain_model      = RST_OUTPUT_GAIN;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field extremes, saturation both ways, dither extremes
        queue_item(16'sd0, 16'sd0);
        queue_item(16'sh7FFF, 16'sd0);
        queue_item(-16'sh8000, 16'sd0);
        queue_item(16'sh7FFF, 16'sh7FFF);
        queue_item(-16'sh8000, -16'sh8000);
        queue_item(16'sd0, 16'sh7FFF);
        queue_item(16'sd0, -16'sh8000);
        queue_item(16'sh5555, 16'shAAAA);
        wait_idle();

        // all taps minus one, full gain, dither off
        set_config(5'd16, 32'hFFFF_FFFF, 1'b0, 16'hFFFF);
        repeat (3) queue_item(16'sh7FFF, -16'sh8000);
        repeat (3) queue_item(-16'sh8000, 16'sh7FFF);
        wait_idle();

        // tap count beyond the ring size, meaningless weight code mixed in
        set_config(5'd17, 32'h9999_9999, 1'b1, 16'h8000);
        repeat (4) queue_random_item();
        wait_idle();
        // park the write slot high so the next, shorter ring starts stale
        fill = (13 - int'(wr_slot_model) + MAX_TAPS_DEF) % MAX_TAPS_DEF;
        repeat (fill) queue_random_item();
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tc = ($urandom_range(9) == 0) ? TC_BITS'($urandom_range(31))
                                          : TC_BITS'($urandom_range(16, 1));
            w  = $urandom;
            de = ($urandom_range(1) != 0);
            case ($urandom_range(3))
                0:       g = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: g = GAIN_BITS'($urandom_range(65535));
            endcase
            case (ph)
                0: begin tc = 5'd0; de = 1'b1; g = 16'hFFFF; end
                1: begin tc = 5'd31; w = 32'h5555_5555; g = 16'hFFFF; end
                2: begin tc = 5'd1; de = 1'b0; g = 16'h0000; end
                3: begin tc = 5'd16; w = 32'hFFFF_FFFF; de = 1'b1; end
                default: ;
            endcase
            set_config(tc, w, de, g);
            steady = (ph == 5);
            if (ph == 1) hold_reqs++;   // long output stall while items keep coming
            repeat (PHASE_ITEMS) queue_random_item();
            wait_idle();
        end

        if (fail_count == 0 && pending_filtered.size() == 0) begin
            $display("ternary_fir_filter_top_tb OK");
        end else begin
            $display("ternary_fir_filter_top_tb NOT OK");
        end
        $finish;
    end

endmodule
